/* rtl/salc_pkg.sv */
// Shared types and constants for the set-associative LRU cache model.
// No dependencies.
`default_nettype none
package salc_pkg;
	localparam int MaxSetBits = 6;
	localparam int MaxWays    = 8;
	localparam int SetCount   = 1 << MaxSetBits;
	localparam int WayBits    = (MaxWays > 1) ? $clog2(MaxWays) : 1;
	localparam int WayCntBits = $clog2(MaxWays + 1);
	localparam int SetBits    = (MaxSetBits > 0) ? MaxSetBits : 1;
	localparam int RankBits   = WayBits;
	localparam int RowWidth   = MaxWays * (32 + RankBits);

	localparam logic [1:0] CFG_OFFSET = 2'd0;
	localparam logic [1:0] CFG_SETS   = 2'd1;
	localparam logic [1:0] CFG_WAYS   = 2'd2;

	typedef struct packed {
		logic clear;   // write one set of the clearing pass
		logic load;    // latch a new item
		logic lookup;  // capture set row, evaluate
		logic commit;  // write back row, update totals
	} salc_cmd_t;

	typedef struct packed {
		logic clr_last; // clearing pass is at its last set
		logic second;   // current access is the second of a modify
		logic is_mod;
	} salc_sts_t;
endpackage
`default_nettype wire

/* rtl/set_assoc_lru_cache_model_core.sv */
// Top level of the set-associative LRU cache model.
// Depends on salc_pkg, salc_ctrl, salc_dp, salc_ram.
//
//  channel | handshake              | payload
//  cfg     | cfg_valid/cfg_ready    | cfg_index, cfg_data
//  in      | in_valid/in_ready      | op, address
//  out     | out_valid/out_ready    | hit, evicted, last, *_total
//
// Each access sets the address, does a registered row read, then evaluates and
// writes back; after its accept a load/store item makes one access, a modify two.
// A result is registered when its access commits. One item at a time.
// After reset a clearing pass writes all 64 sets, with in_ready low.
// A stalled result holds the write back until the output register frees.
`default_nettype none
module set_assoc_lru_cache_model_core import salc_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [31:0] cfg_data,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         op,
	input  wire  [31:0] address,
	output logic        out_valid,
	input  wire         out_ready,
	output logic        hit,
	output logic        evicted,
	output logic        last,
	output logic [31:0] hit_total,
	output logic [31:0] miss_total,
	output logic [31:0] evict_total
);
	salc_cmd_t cmd;
	salc_sts_t sts;
	assign cfg_ready = 1'b1;

	salc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
	);
	salc_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.op(op), .address(address), .hit(hit), .evicted(evicted), .last(last),
		.hit_total(hit_total), .miss_total(miss_total), .evict_total(evict_total)
	);
endmodule
`default_nettype wire

/* rtl/salc_ram.sv */
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
`default_nettype none
module salc_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(Depth)-1:0] waddr,
	input  wire [Width-1:0]         wdata,
	input  wire [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]        rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* rtl/salc_ctrl.sv */
// Controller: runs the clearing pass and sequences load, lookup and commit for each item.
// Depends on salc_pkg.
`default_nettype none
module salc_ctrl import salc_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  wire        out_ready,
	input  salc_sts_t  sts,
	output salc_cmd_t  cmd
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_LOOK  = 3'd2;
	localparam logic [2:0] ST_EVAL  = 3'd3;
	localparam logic [2:0] ST_CLEAR = 3'd4;

	logic [2:0] state_q;
	logic       ov_q;
	logic       out_free;

	assign out_free  = !ov_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = ov_q;

	always_comb begin
		cmd = '0;
		cmd.clear  = (state_q == ST_CLEAR);
		cmd.load   = in_valid && in_ready;
		cmd.lookup = (state_q == ST_LOOK);
		cmd.commit = (state_q == ST_EVAL) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ov_q    <= 1'b0;
		end else begin
			if (cmd.commit) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			case (state_q)
				ST_CLEAR: if (sts.clr_last) state_q <= ST_IDLE;
				ST_IDLE: if (in_valid) state_q <= ST_READ;
				ST_READ: state_q <= ST_LOOK;
				ST_LOOK: state_q <= ST_EVAL;
				ST_EVAL: if (out_free) begin
					state_q <= (sts.is_mod && !sts.second) ? ST_READ : ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_commit_frees: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid) else $error("result not presented");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !cmd.load) else $error("load while busy");
	a_lookup_then: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.lookup |=> state_q == ST_EVAL) else $error("lookup sequence broken");
endmodule
`default_nettype wire

/* rtl/salc_dp.sv */
// Datapath: address split, set row memory, hit/victim choice, LRU ranks, totals.
// Depends on salc_pkg and salc_ram.
`default_nettype none
module salc_dp import salc_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  salc_cmd_t   cmd,
	output salc_sts_t   sts,
	input  wire         cfg_valid,
	input  wire  [1:0]  cfg_index,
	input  wire  [31:0] cfg_data,
	input  wire         op,
	input  wire  [31:0] address,
	output logic        hit,
	output logic        evicted,
	output logic        last,
	output logic [31:0] hit_total,
	output logic [31:0] miss_total,
	output logic [31:0] evict_total
);
	logic [4:0] off_q;
	logic [2:0] sets_q;
	logic [3:0] ways_q;
	logic       op_q, second_q;
	logic [31:0] addr_q;
	logic [SetBits-1:0] clr_q;

	// address split
	logic [2:0]  sb;
	logic [5:0]  shift;
	logic [31:0] shifted;
	logic [SetBits-1:0] set_idx;
	logic [31:0] tag;
	logic [WayCntBits-1:0] nways;

	always_comb begin
		sb = (32'(sets_q) > MaxSetBits) ? 3'(MaxSetBits) : sets_q;
		shifted = addr_q >> off_q;
		set_idx = SetBits'(shifted & ((32'd1 << sb) - 32'd1));
		shift = 6'(off_q) + 6'(sb);
		tag = (shift >= 6'd32) ? 32'd0 : (shifted >> sb);
		if (ways_q == 4'd0) nways = WayCntBits'(1);
		else if (32'(ways_q) > MaxWays) nways = WayCntBits'(MaxWays);
		else nways = WayCntBits'(ways_q);
	end

	// the clearing pass after reset owns the write port until it ends
	logic                ram_we;
	logic [SetBits-1:0]  ram_waddr;
	logic [RowWidth-1:0] row_rd, row_wr, row_wd;
	logic [MaxWays-1:0]  vld_rd, vld_wr, vld_wd;
	assign ram_we    = cmd.commit || cmd.clear;
	assign ram_waddr = cmd.clear ? clr_q : set_idx;
	assign row_wd    = cmd.clear ? '0 : row_wr;
	assign vld_wd    = cmd.clear ? '0 : vld_wr;

	salc_ram #(.Width(RowWidth), .Depth(SetCount)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(row_wd),
		.raddr(set_idx), .rdata(row_rd)
	);
	salc_ram #(.Width(MaxWays), .Depth(SetCount)) u_vram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(vld_wd),
		.raddr(set_idx), .rdata(vld_rd)
	);

	// registered lookup results
	logic [RowWidth-1:0] row_s1;
	logic [MaxWays-1:0]  vld_s1;
	logic                hit_s1, ev_s1;
	logic [WayBits-1:0]  tgt_s1;

	logic [MaxWays-1:0] inuse, vld_now, match;
	logic               h_c, free_c;
	logic [WayBits-1:0] hw_c, fw_c, vw_c, tgt_c;
	logic [RankBits-1:0] best;
	always_comb begin
		vld_now = vld_rd;
		h_c = 1'b0; free_c = 1'b0; hw_c = '0; fw_c = '0; vw_c = '0; best = '0;
		for (int w = 0; w < MaxWays; w++) begin
			inuse[w] = (w < 32'(nways));
			match[w] = inuse[w] && vld_now[w]
				&& row_rd[w*(32+RankBits) +: 32] == tag;
		end
		for (int w = MaxWays-1; w >= 0; w--) begin
			if (match[w]) begin h_c = 1'b1; hw_c = WayBits'(w); end
			if (inuse[w] && !vld_now[w]) begin free_c = 1'b1; fw_c = WayBits'(w); end
		end
		for (int w = 0; w < MaxWays; w++) begin
			if (inuse[w] && row_rd[w*(32+RankBits)+32 +: RankBits] > best) begin
				best = row_rd[w*(32+RankBits)+32 +: RankBits];
				vw_c = WayBits'(w);
			end
		end
		tgt_c = h_c ? hw_c : (free_c ? fw_c : vw_c);
	end

	// commit: rank update and tag write
	logic [RankBits:0] oldr;
	logic [RankBits-1:0] rk;
	always_comb begin
		row_wr = row_s1;
		vld_wr = vld_s1 | (MaxWays'(1) << tgt_s1);
		oldr = (!hit_s1 && !ev_s1) ? {1'b1, {RankBits{1'b1}}}
			: {1'b0, row_s1[32'(tgt_s1)*(32+RankBits)+32 +: RankBits]};
		for (int w = 0; w < MaxWays; w++) begin
			rk = row_s1[w*(32+RankBits)+32 +: RankBits];
			if (w == 32'(tgt_s1)) begin
				row_wr[w*(32+RankBits)+32 +: RankBits] = '0;
				if (!hit_s1) row_wr[w*(32+RankBits) +: 32] = tag;
			end else if (w < 32'(nways) && vld_s1[w] && {1'b0, rk} < oldr
				&& 32'(rk) < MaxWays-1) begin
				row_wr[w*(32+RankBits)+32 +: RankBits] = rk + RankBits'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) addr_q <= address;
		if (cmd.lookup) begin
			row_s1 <= row_rd; vld_s1 <= vld_now;
			hit_s1 <= h_c; ev_s1 <= !h_c && !free_c; tgt_s1 <= tgt_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= 5'd4; sets_q <= 3'd4; ways_q <= 4'd1;
			op_q <= 1'b0; second_q <= 1'b0;
			clr_q <= '0;
			hit_total <= '0; miss_total <= '0; evict_total <= '0;
			hit <= 1'b0; evicted <= 1'b0; last <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_OFFSET: off_q  <= cfg_data[4:0];
					CFG_SETS:   sets_q <= cfg_data[2:0];
					CFG_WAYS:   ways_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (cmd.clear) clr_q <= clr_q + SetBits'(1);
			if (cmd.load) begin op_q <= op; second_q <= 1'b0; end
			if (cmd.commit) begin
				second_q <= 1'b1;
				hit <= hit_s1; evicted <= ev_s1;
				last <= !op_q || second_q;
				if (hit_s1) begin
					if (hit_total != '1) hit_total <= hit_total + 32'd1;
				end else begin
					if (miss_total != '1) miss_total <= miss_total + 32'd1;
					if (ev_s1 && evict_total != '1) evict_total <= evict_total + 32'd1;
				end
			end
		end
	end

	assign sts.clr_last = (clr_q == SetBits'(SetCount - 1));
	assign sts.second   = second_q;
	assign sts.is_mod   = op_q;

	a_ev_miss: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(hit_s1 && ev_s1)) else $error("evict on hit");
	a_second_hits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && second_q |-> hit_s1) else $error("second access missed");
	a_miss_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && !hit_s1 && $past(miss_total) != '1 |=> miss_total != '0)
		else $error("miss total not advanced");
endmodule
`default_nettype wire
